### rtl/core/ipv4_header_generator_macros.svh
// Assertion macros shared by the IPv4 header generator RTL.
`ifndef IPV4_HEADER_GENERATOR_MACROS_SVH
`define IPV4_HEADER_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds at every clock edge out of reset.
`define IHG_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ihg assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define IHG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihg assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define IHG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihg assertion failed");

`else

`define IHG_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define IHG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IHG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/ihg_pkg.sv
// Types, constants and helper functions of the IPv4 header generator.
`timescale 1ns / 1ps

package ihg_pkg;

    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TOS_VALUE   = 8'h00;
    localparam logic [7:0]  TTL_VALUE   = 8'd128;
    localparam logic [15:0] FRAG_VALUE  = 16'h0000;
    localparam logic [15:0] HDR_BYTES   = 16'd20;

    localparam int NUM_WORDS = 5;
    localparam int BEAT_W    = $clog2(NUM_WORDS);
    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(NUM_WORDS - 1);

    // Raw sum of nine 16-bit terms; the fixed ones keep it below 2^19.
    localparam int SUM_W = 19;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [BEAT_W-1:0] {
        BEAT_LEN   = 3'd0,
        BEAT_IDENT = 3'd1,
        BEAT_TTL   = 3'd2,
        BEAT_SRC   = 3'd3,
        BEAT_DST   = 3'd4
    } beat_t;

    typedef struct packed {
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [7:0]  protocol;
        logic [15:0] checksum;
        logic [31:0] source;
        logic [31:0] dest;
    } hdr_t;

    // End-around carry fold of the raw sum, then complement.
    function automatic logic [15:0] header_checksum(input logic [SUM_W-1:0] raw);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, raw[15:0]} + 17'(raw[SUM_W-1:16]);
        s2 = s1[15:0] + 16'(s1[16]);
        return ~s2;
    endfunction

    // Pick one 32-bit header word in network byte order.
    function automatic logic [31:0] header_word_at(input hdr_t h, input logic [BEAT_W-1:0] b);
        logic [31:0] w;
        case (beat_t'(b))
            BEAT_LEN:   w = {VER_IHL, TOS_VALUE, h.total_length};
            BEAT_IDENT: w = {h.ident, FRAG_VALUE};
            BEAT_TTL:   w = {TTL_VALUE, h.protocol, h.checksum};
            BEAT_SRC:   w = h.source;
            BEAT_DST:   w = h.dest;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/ihg_ifs.sv
// Channel interfaces of the IPv4 header generator: requests, words, configuration.
`timescale 1ns / 1ps

interface ihg_req_if;
    logic        valid;
    logic        ready;
    logic        use_own_source;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  protocol_number;
    logic [15:0] payload_length;

    modport source (output valid, use_own_source, source_address, dest_address,
                    protocol_number, payload_length, input ready);
    modport sink   (input valid, use_own_source, source_address, dest_address,
                    protocol_number, payload_length, output ready);
endinterface

interface ihg_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic        last_word;

    modport source (output valid, header_word, last_word, input ready);
    modport sink   (input valid, header_word, last_word, output ready);
endinterface

interface ihg_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] own_address;

    modport source (output valid, own_address, input ready);
    modport sink   (input valid, own_address, output ready);
endinterface

### rtl/core/ihg_front.sv
// Request front end: source select, identification counter and checksum sum.
`timescale 1ns / 1ps
`include "ipv4_header_generator_macros.svh"

module ihg_front
    import ihg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ihg_cfg_if.sink    cfg,
    ihg_req_if.sink    req,
    output logic       push_valid,
    input  logic       push_ready,
    output hdr_t       push_data
);

    logic [31:0]      own_address_reg;
    logic [15:0]      ident_reg;
    logic [15:0]      ident_next;
    logic             stage_valid_reg;
    logic             stage_valid_next;
    hdr_t             stage_hdr_reg;
    hdr_t             stage_hdr_next;
    logic [SUM_W-1:0] raw_sum_reg;
    logic [SUM_W-1:0] raw_sum_next;
    logic             in_accept;
    logic [31:0]      src_sel;
    logic [15:0]      hdr_total;

    assign cfg.ready  = 1'b1;
    assign req.ready  = !stage_valid_reg || push_ready;
    assign in_accept  = req.valid && req.ready;

    always_comb
    begin
        src_sel   = req.use_own_source ? own_address_reg : req.source_address;
        hdr_total = req.payload_length + HDR_BYTES;

        stage_hdr_next.total_length = hdr_total;
        stage_hdr_next.ident        = ident_reg;
        stage_hdr_next.protocol     = req.protocol_number;
        stage_hdr_next.checksum     = '0;
        stage_hdr_next.source       = src_sel;
        stage_hdr_next.dest         = req.dest_address;

        // Sum every 16-bit header half-word with the checksum field at zero.
        raw_sum_next = SUM_W'({VER_IHL, TOS_VALUE}) + SUM_W'(hdr_total)
                     + SUM_W'(ident_reg) + SUM_W'(FRAG_VALUE)
                     + SUM_W'({TTL_VALUE, req.protocol_number})
                     + SUM_W'(src_sel[31:16]) + SUM_W'(src_sel[15:0])
                     + SUM_W'(req.dest_address[31:16]) + SUM_W'(req.dest_address[15:0]);

        ident_next       = in_accept ? ident_reg + 16'd1 : ident_reg;
        stage_valid_next = in_accept || (stage_valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            ident_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                own_address_reg <= cfg.own_address;
            end
            ident_reg       <= ident_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_hdr_reg <= stage_hdr_next;
            raw_sum_reg   <= raw_sum_next;
        end
    end

    always_comb
    begin
        push_data          = stage_hdr_reg;
        push_data.checksum = header_checksum(raw_sum_reg);
    end

    assign push_valid = stage_valid_reg;

    `IHG_ASSERT_NEXT(a_ident_advance, clk, rst_n, in_accept,
                     ident_reg == 16'($past(ident_reg) + 16'd1))

endmodule

### rtl/core/ihg_queue.sv
// Short header queue between the front end and the word serializer.
`timescale 1ns / 1ps
`include "ipv4_header_generator_macros.svh"

module ihg_queue
    import ihg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  hdr_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output hdr_t pop_data
);

    hdr_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `IHG_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `IHG_ASSERT_NEXT(a_count_grow, clk, rst_n, push_fire && !pop_fire,
                     count_reg == QCNT_W'($past(count_reg) + 1'b1))

endmodule

### rtl/core/ihg_back.sv
// Word serializer: emits each queued header as five 32-bit beats.
`timescale 1ns / 1ps
`include "ipv4_header_generator_macros.svh"

module ihg_back
    import ihg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  hdr_t        pop_data,
    ihg_word_if.source  hdr
);

    hdr_t              hdr_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [BEAT_W-1:0] beat_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_fire;
    logic              at_last;
    logic              load;

    assign at_last   = beat_reg == LAST_BEAT;
    assign out_fire  = out_valid_reg && hdr.ready;
    assign pop_ready = !out_valid_reg || (out_fire && at_last);
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            beat_next      = '0;
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                beat_next      = '0;
                out_valid_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg <= pop_data;
        end
    end

    assign hdr.valid       = out_valid_reg;
    assign hdr.header_word = header_word_at(hdr_reg, beat_reg);
    assign hdr.last_word   = at_last;

    `IHG_ASSERT_ALWAYS(a_beat_bound, clk, rst_n, beat_reg <= LAST_BEAT)
    `IHG_ASSERT_NEXT(a_drain_idle, clk, rst_n, out_fire && at_last && !pop_valid,
                     !out_valid_reg)

endmodule

### rtl/core/ipv4_header_generator.sv
// IPv4 header generator: top level joining front end, queue and serializer.
//
// Usage:
//   cfg  : write beat sets own_address, the local IPv4 address (always ready).
//          Write it only while the block is idle.
//   req  : one beat per header request (source choice, addresses, protocol,
//          payload length). Each accepted beat takes the current
//          identification value; the 16-bit counter then advances and wraps.
//   hdr  : five beats per request, header words 0..4 in network byte order,
//          last_word high on the fifth beat.
// Path: an accepted request passes the front stage, the queue and the
//   serializer register before its first word is valid.
// Throughput: bounded by the single 32-bit output channel, five beats per
//   header; the serializer moves from the last beat of one header straight
//   to the first beat of the next. The front end takes a request every cycle
//   until its stage and the two-entry queue are full.
// Reset: clears own_address, the identification counter and all valid state.
// Stall: when hdr.ready is low the current word holds; the queue and the
//   front stage fill and then req.ready drops.
`timescale 1ns / 1ps

module ipv4_header_generator
    import ihg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ihg_cfg_if.sink     cfg,
    ihg_req_if.sink     req,
    ihg_word_if.source  hdr
);

    // Front end to queue.
    logic push_valid;
    logic push_ready;
    hdr_t push_data;

    // Queue to serializer.
    logic pop_valid;
    logic pop_ready;
    hdr_t pop_data;

    // Accept requests, pick the source and register the checksum sum.
    ihg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple request intake from word output.
    ihg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Serialize each header into five word beats.
    ihg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .hdr       (hdr)
    );

endmodule
